// ===== design/rmq_pkg.sv =====
// Shared widths and constants for the rotation matrix to quaternion pipeline.
// No dependencies; used by every module of the block.
`default_nettype none
package rmq_pkg;

    // Q2.30 operand format
    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 30;
    // sum or difference of two entries
    localparam int NUM_W   = DATA_W + 1;
    // radicand before clamping (sum of three entries plus one)
    localparam int RADI_W  = DATA_W + 3;
    // integer square root input and result
    localparam int RAD_W   = 2 * DATA_W;
    localparam int ROOT_W  = DATA_W;
    // quotient bits kept before saturation
    localparam int QUOT_W  = DATA_W + 1;
    // number of quotient lanes
    localparam int LANES   = 3;

    localparam logic signed [RADI_W-1:0] ONE_Q30 = RADI_W'(64'sd1 <<< FRAC_W);
    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // slot that receives s/2: 0..2 = x,y,z for the diagonal branch, 3 = w for trace > 0
    localparam int SLOT_W = 2;
    localparam logic [SLOT_W-1:0] SLOT_X     = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_Y     = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_Z     = 2'd2;
    localparam logic [SLOT_W-1:0] SLOT_TRACE = 2'd3;

    // side band widths through the root and divide pipelines
    localparam int SQ_SIDE_W = LANES * NUM_W + SLOT_W;
    localparam int DV_SIDE_W = SLOT_W + DATA_W;

endpackage
`default_nettype wire

// ===== design/rmq_isqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Depends on rmq_pkg for widths.
`default_nettype none
module rmq_isqrt #(
    parameter int SIDE_W = rmq_pkg::SQ_SIDE_W
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [rmq_pkg::RAD_W-1:0]     in_rad,
    input  wire logic [SIDE_W-1:0]             in_side,
    output logic                               out_valid,
    output logic [rmq_pkg::ROOT_W-1:0]         out_root,
    output logic [SIDE_W-1:0]                  out_side
);
    localparam int STEPS  = rmq_pkg::ROOT_W;
    localparam int RAD_W  = rmq_pkg::RAD_W;
    localparam int ROOT_W = rmq_pkg::ROOT_W;
    localparam int REM_W  = ROOT_W + 4;

    logic [REM_W-1:0]  rem_reg  [STEPS];
    logic [ROOT_W-1:0] root_reg [STEPS];
    logic [RAD_W-1:0]  rad_reg  [STEPS];
    logic [SIDE_W-1:0] side_reg [STEPS];
    logic              valid_reg [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [REM_W-1:0]  rem_prev;
        logic [ROOT_W-1:0] root_prev;
        logic [RAD_W-1:0]  rad_prev;
        logic [SIDE_W-1:0] side_prev;
        logic              valid_prev;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic              ge;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        if (k == 0) begin : g_first
            assign rem_prev   = '0;
            assign root_prev  = '0;
            assign rad_prev   = in_rad;
            assign side_prev  = in_side;
            assign valid_prev = in_valid;
        end else begin : g_rest
            assign rem_prev   = rem_reg[k-1];
            assign root_prev  = root_reg[k-1];
            assign rad_prev   = rad_reg[k-1];
            assign side_prev  = side_reg[k-1];
            assign valid_prev = valid_reg[k-1];
        end

        // bring down two radicand bits, try root*4+1
        assign rem_sh    = {rem_prev[REM_W-3:0], rad_prev[RAD_W-1 -: 2]};
        assign trial     = {{(REM_W-ROOT_W-2){1'b0}}, root_prev, 2'b01};
        assign ge        = (rem_sh >= trial);
        assign rem_next  = ge ? (rem_sh - trial) : rem_sh;
        assign root_next = {root_prev[ROOT_W-2:0], ge};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                rad_reg[k]  <= {rad_prev[RAD_W-3:0], 2'b00};
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign out_root  = root_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

endmodule
`default_nettype wire

// ===== design/rmq_divider.sv =====
// Pipelined restoring divider: three numerators by one shared divisor, d*2^29/s,
// truncated toward zero and saturated to 32 bits. Depends on rmq_pkg.
`default_nettype none
module rmq_divider #(
    parameter int SIDE_W = rmq_pkg::DV_SIDE_W
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                en,
    input  wire logic                                in_valid,
    input  wire logic [rmq_pkg::ROOT_W-1:0]          in_div,
    input  wire logic signed [rmq_pkg::NUM_W-1:0]    in_num [rmq_pkg::LANES],
    input  wire logic [SIDE_W-1:0]                   in_side,
    output logic                                     out_valid,
    output logic signed [rmq_pkg::DATA_W-1:0]        out_quot [rmq_pkg::LANES],
    output logic [SIDE_W-1:0]                        out_side
);
    localparam int LANES  = rmq_pkg::LANES;
    localparam int NUM_W  = rmq_pkg::NUM_W;
    localparam int DIV_W  = rmq_pkg::ROOT_W;
    localparam int QUOT_W = rmq_pkg::QUOT_W;
    localparam int DATA_W = rmq_pkg::DATA_W;
    localparam int STEPS  = QUOT_W;
    // numerator is |d| << 29; top part |d| >> 4 seeds the remainder
    localparam int PRE_SH = 4;
    localparam int LOW_W  = QUOT_W;

    // shared control through the step stages
    logic              setup_valid_reg;
    logic [DIV_W-1:0]  setup_div_reg;
    logic [SIDE_W-1:0] setup_side_reg;
    logic              valid_reg [STEPS];
    logic [DIV_W-1:0]  div_reg   [STEPS];
    logic [SIDE_W-1:0] side_reg  [STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setup_valid_reg <= 1'b0;
        end else if (en) begin
            setup_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            setup_div_reg  <= in_div;
            setup_side_reg <= in_side;
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_ctl
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= (k == 0) ? setup_valid_reg : valid_reg[(k == 0) ? 0 : k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                div_reg[k]  <= (k == 0) ? setup_div_reg  : div_reg[(k == 0) ? 0 : k-1];
                side_reg[k] <= (k == 0) ? setup_side_reg : side_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    for (genvar n = 0; n < LANES; n++) begin : g_lane
        logic [NUM_W-1:0]  mag;
        logic              ovf;
        logic [DIV_W-1:0]  s_rem_reg;
        logic [LOW_W-1:0]  s_low_reg;
        logic              s_neg_reg;
        logic              s_ovf_reg;
        logic              s_zero_reg;
        logic [DIV_W-1:0]  rem_reg  [STEPS];
        logic [LOW_W-1:0]  low_reg  [STEPS];
        logic [QUOT_W-1:0] quot_reg [STEPS];
        logic              neg_reg  [STEPS];
        logic              ovf_reg  [STEPS];
        logic              zero_reg [STEPS];
        logic [QUOT_W-1:0] q_fin;

        // setup: magnitude, overflow when |d| >= 16*s (quotient needs more than 33 bits)
        assign mag = in_num[n][NUM_W-1] ? NUM_W'(-in_num[n]) : NUM_W'(in_num[n]);
        assign ovf = ({{(PRE_SH-1){1'b0}}, mag} >= {in_div, {PRE_SH{1'b0}}});

        always_ff @(posedge aclk) begin
            if (en) begin
                s_rem_reg  <= DIV_W'(mag >> PRE_SH);
                s_low_reg  <= {mag[PRE_SH-1:0], {(LOW_W-PRE_SH){1'b0}}};
                s_neg_reg  <= in_num[n][NUM_W-1];
                s_ovf_reg  <= ovf;
                s_zero_reg <= (in_num[n] == '0);
            end
        end

        for (genvar k = 0; k < STEPS; k++) begin : g_step
            logic [DIV_W-1:0]  rem_prev;
            logic [LOW_W-1:0]  low_prev;
            logic [QUOT_W-1:0] quot_prev;
            logic [DIV_W-1:0]  div_prev;
            logic              neg_prev;
            logic              ovf_prev;
            logic              zero_prev;
            logic [DIV_W:0]    rem_sh;
            logic              ge;
            logic [DIV_W:0]    rem_next;

            if (k == 0) begin : g_first
                assign rem_prev  = s_rem_reg;
                assign low_prev  = s_low_reg;
                assign quot_prev = '0;
                assign div_prev  = setup_div_reg;
                assign neg_prev  = s_neg_reg;
                assign ovf_prev  = s_ovf_reg;
                assign zero_prev = s_zero_reg;
            end else begin : g_rest
                assign rem_prev  = rem_reg[k-1];
                assign low_prev  = low_reg[k-1];
                assign quot_prev = quot_reg[k-1];
                assign div_prev  = div_reg[k-1];
                assign neg_prev  = neg_reg[k-1];
                assign ovf_prev  = ovf_reg[k-1];
                assign zero_prev = zero_reg[k-1];
            end

            // one restoring step
            assign rem_sh   = {rem_prev, low_prev[LOW_W-1]};
            assign ge       = (rem_sh >= {1'b0, div_prev});
            assign rem_next = ge ? (rem_sh - {1'b0, div_prev}) : rem_sh;

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k]  <= rem_next[DIV_W-1:0];
                    low_reg[k]  <= {low_prev[LOW_W-2:0], 1'b0};
                    quot_reg[k] <= {quot_prev[QUOT_W-2:0], ge};
                    neg_reg[k]  <= neg_prev;
                    ovf_reg[k]  <= ovf_prev;
                    zero_reg[k] <= zero_prev;
                end
            end
        end

        // sign and saturation
        assign q_fin = quot_reg[STEPS-1];
        always_comb begin
            if (zero_reg[STEPS-1]) begin
                out_quot[n] = '0;
            end else if (ovf_reg[STEPS-1]) begin
                out_quot[n] = neg_reg[STEPS-1] ? rmq_pkg::SAT_MIN : rmq_pkg::SAT_MAX;
            end else if (neg_reg[STEPS-1]) begin
                if (q_fin > {1'b0, rmq_pkg::SAT_MIN}) begin
                    out_quot[n] = rmq_pkg::SAT_MIN;
                end else begin
                    out_quot[n] = DATA_W'(-q_fin);
                end
            end else begin
                if (q_fin > {1'b0, rmq_pkg::SAT_MAX}) begin
                    out_quot[n] = rmq_pkg::SAT_MAX;
                end else begin
                    out_quot[n] = q_fin[DATA_W-1:0];
                end
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

endmodule
`default_nettype wire

// ===== design/rotation_matrix_to_quaternion.sv =====
// Rotation matrix to quaternion converter. Nine Q2.30 entries (column-major) enter as
// one transaction and one Q2.30 quaternion leaves, saturated to 32 bits. The block
// takes one transaction per cycle unless the result side stalls. It has two front-end
// stages (trace, diagonal pick, radicand and numerators), 32 stages of the bit-serial
// square root, one setup and 33 stages of the shared-divisor divider, and the output
// register. A stall on the result side freezes the whole pipeline; bubbles move with it.
// Depends on rmq_pkg, rmq_isqrt and rmq_divider.
`default_nettype none
module rotation_matrix_to_quaternion (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic signed [rmq_pkg::DATA_W-1:0] s_col0_x,
    input  wire logic signed [rmq_pkg::DATA_W-1:0] s_col0_y,
    input  wire logic signed [rmq_pkg::DATA_W-1:0] s_col0_z,
    input  wire logic signed [rmq_pkg::DATA_W-1:0] s_col1_x,
    input  wire logic signed [rmq_pkg::DATA_W-1:0] s_col1_y,
    input  wire logic signed [rmq_pkg::DATA_W-1:0] s_col1_z,
    input  wire logic signed [rmq_pkg::DATA_W-1:0] s_col2_x,
    input  wire logic signed [rmq_pkg::DATA_W-1:0] s_col2_y,
    input  wire logic signed [rmq_pkg::DATA_W-1:0] s_col2_z,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic signed [rmq_pkg::DATA_W-1:0]     m_quat_x,
    output logic signed [rmq_pkg::DATA_W-1:0]     m_quat_y,
    output logic signed [rmq_pkg::DATA_W-1:0]     m_quat_z,
    output logic signed [rmq_pkg::DATA_W-1:0]     m_quat_w
);
    localparam int DATA_W = rmq_pkg::DATA_W;
    localparam int NUM_W  = rmq_pkg::NUM_W;
    localparam int RADI_W = rmq_pkg::RADI_W;
    localparam int RAD_W  = rmq_pkg::RAD_W;
    localparam int ROOT_W = rmq_pkg::ROOT_W;
    localparam int FRAC_W = rmq_pkg::FRAC_W;
    localparam int SLOT_W = rmq_pkg::SLOT_W;
    localparam int LANES  = rmq_pkg::LANES;
    localparam int TR_W   = DATA_W + 2;
    localparam int SQ_SIDE_W = rmq_pkg::SQ_SIDE_W;
    localparam int DV_SIDE_W = rmq_pkg::DV_SIDE_W;

    logic en;
    logic out_valid_reg;

    // whole pipeline moves unless a finished result is held
    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    // ---------------- stage 1: trace and largest diagonal ----------------
    logic signed [TR_W-1:0]   trace;
    logic                     g10;
    logic signed [DATA_W-1:0] best;
    logic [SLOT_W-1:0]        pick;

    assign trace = TR_W'(s_col0_x) + TR_W'(s_col1_y) + TR_W'(s_col2_z);
    assign g10   = (s_col1_y > s_col0_x);
    assign best  = g10 ? s_col1_y : s_col0_x;
    assign pick  = (s_col2_z > best) ? rmq_pkg::SLOT_Z :
                   (g10 ? rmq_pkg::SLOT_Y : rmq_pkg::SLOT_X);

    logic                     v1_reg;
    logic signed [DATA_W-1:0] m1_reg [9];
    logic signed [TR_W-1:0]   trace1_reg;
    logic [SLOT_W-1:0]        slot1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_reg[0]  <= s_col0_x;
            m1_reg[1]  <= s_col0_y;
            m1_reg[2]  <= s_col0_z;
            m1_reg[3]  <= s_col1_x;
            m1_reg[4]  <= s_col1_y;
            m1_reg[5]  <= s_col1_z;
            m1_reg[6]  <= s_col2_x;
            m1_reg[7]  <= s_col2_y;
            m1_reg[8]  <= s_col2_z;
            trace1_reg <= trace;
            slot1_reg  <= (trace > 0) ? rmq_pkg::SLOT_TRACE : pick;
        end
    end

    // ---------------- stage 2: radicand and numerators ----------------
    // entry of column c, row r is m1_reg[3c + r]
    logic signed [RADI_W-1:0] radi;
    logic signed [NUM_W-1:0]  num_a;
    logic signed [NUM_W-1:0]  num_b;
    logic signed [NUM_W-1:0]  num_c;
    logic signed [NUM_W-1:0]  d10_01;
    logic signed [NUM_W-1:0]  d02_20;
    logic signed [NUM_W-1:0]  d21_12;
    logic signed [NUM_W-1:0]  s10_01;
    logic signed [NUM_W-1:0]  s02_20;
    logic signed [NUM_W-1:0]  s21_12;
    logic signed [RADI_W-1:0] dg0;
    logic signed [RADI_W-1:0] dg1;
    logic signed [RADI_W-1:0] dg2;

    assign d21_12 = NUM_W'(m1_reg[7]) - NUM_W'(m1_reg[5]);
    assign d02_20 = NUM_W'(m1_reg[2]) - NUM_W'(m1_reg[6]);
    assign d10_01 = NUM_W'(m1_reg[3]) - NUM_W'(m1_reg[1]);
    assign s21_12 = NUM_W'(m1_reg[7]) + NUM_W'(m1_reg[5]);
    assign s02_20 = NUM_W'(m1_reg[2]) + NUM_W'(m1_reg[6]);
    assign s10_01 = NUM_W'(m1_reg[3]) + NUM_W'(m1_reg[1]);
    assign dg0    = RADI_W'(m1_reg[0]);
    assign dg1    = RADI_W'(m1_reg[4]);
    assign dg2    = RADI_W'(m1_reg[8]);

    // lane a: w numerator (or x), lane b: q[j] (or y), lane c: q[k] (or z)
    always_comb begin
        unique case (slot1_reg)
            rmq_pkg::SLOT_X: begin
                radi  = dg0 - (dg1 + dg2) + rmq_pkg::ONE_Q30;
                num_a = d21_12;
                num_b = s10_01;
                num_c = s02_20;
            end
            rmq_pkg::SLOT_Y: begin
                radi  = dg1 - (dg2 + dg0) + rmq_pkg::ONE_Q30;
                num_a = d02_20;
                num_b = s21_12;
                num_c = s10_01;
            end
            rmq_pkg::SLOT_Z: begin
                radi  = dg2 - (dg0 + dg1) + rmq_pkg::ONE_Q30;
                num_a = d10_01;
                num_b = s02_20;
                num_c = s21_12;
            end
            default: begin
                radi  = RADI_W'(trace1_reg) + rmq_pkg::ONE_Q30;
                num_a = d21_12;
                num_b = d02_20;
                num_c = d10_01;
            end
        endcase
    end

    logic [RAD_W-1:0] rad_shift;

    // clamp to zero, then scale by 2^30 for the Q.30 root
    assign rad_shift = (radi <= 0) ? '0 :
                       {{(RAD_W-(RADI_W-2)-FRAC_W){1'b0}}, radi[RADI_W-3:0], {FRAC_W{1'b0}}};

    logic                   v2_reg;
    logic [RAD_W-1:0]       rad2_reg;
    logic [SQ_SIDE_W-1:0]   side2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad2_reg  <= rad_shift;
            side2_reg <= {num_a, num_b, num_c, slot1_reg};
        end
    end

    // ---------------- square root ----------------
    logic                  sq_valid;
    logic [ROOT_W-1:0]     sq_root;
    logic [SQ_SIDE_W-1:0]  sq_side;

    rmq_isqrt #(
        .SIDE_W (SQ_SIDE_W)
    ) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v2_reg),
        .in_rad    (rad2_reg),
        .in_side   (side2_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // ---------------- quotients ----------------
    logic signed [NUM_W-1:0]  dv_num [LANES];
    logic [SLOT_W-1:0]        sq_slot;
    logic [DATA_W-1:0]        half;
    logic                     dv_valid;
    logic signed [DATA_W-1:0] dv_quot [LANES];
    logic [DV_SIDE_W-1:0]     dv_side;

    assign dv_num[0] = sq_side[SLOT_W + 3*NUM_W - 1 -: NUM_W];
    assign dv_num[1] = sq_side[SLOT_W + 2*NUM_W - 1 -: NUM_W];
    assign dv_num[2] = sq_side[SLOT_W + NUM_W - 1 -: NUM_W];
    assign sq_slot   = sq_side[SLOT_W-1:0];
    assign half      = {1'b0, sq_root[ROOT_W-1:1]};

    rmq_divider #(
        .SIDE_W (DV_SIDE_W)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_div    (sq_root),
        .in_num    (dv_num),
        .in_side   ({sq_slot, half}),
        .out_valid (dv_valid),
        .out_quot  (dv_quot),
        .out_side  (dv_side)
    );

    // ---------------- output register ----------------
    logic [SLOT_W-1:0]        dv_slot;
    logic signed [DATA_W-1:0] dv_half;
    logic signed [DATA_W-1:0] qx_next;
    logic signed [DATA_W-1:0] qy_next;
    logic signed [DATA_W-1:0] qz_next;
    logic signed [DATA_W-1:0] qw_next;

    assign dv_slot = dv_side[DV_SIDE_W-1 -: SLOT_W];
    assign dv_half = dv_side[DATA_W-1:0];

    // route lanes to components: j = i+1, k = i+2 (mod 3)
    always_comb begin
        unique case (dv_slot)
            rmq_pkg::SLOT_X: begin
                qx_next = dv_half;
                qw_next = dv_quot[0];
                qy_next = dv_quot[1];
                qz_next = dv_quot[2];
            end
            rmq_pkg::SLOT_Y: begin
                qy_next = dv_half;
                qw_next = dv_quot[0];
                qz_next = dv_quot[1];
                qx_next = dv_quot[2];
            end
            rmq_pkg::SLOT_Z: begin
                qz_next = dv_half;
                qw_next = dv_quot[0];
                qx_next = dv_quot[1];
                qy_next = dv_quot[2];
            end
            default: begin
                qw_next = dv_half;
                qx_next = dv_quot[0];
                qy_next = dv_quot[1];
                qz_next = dv_quot[2];
            end
        endcase
    end

    logic signed [DATA_W-1:0] qx_reg;
    logic signed [DATA_W-1:0] qy_reg;
    logic signed [DATA_W-1:0] qz_reg;
    logic signed [DATA_W-1:0] qw_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            qx_reg <= qx_next;
            qy_reg <= qy_next;
            qz_reg <= qz_next;
            qw_reg <= qw_next;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_quat_x = qx_reg;
    assign m_quat_y = qy_reg;
    assign m_quat_z = qz_reg;
    assign m_quat_w = qw_reg;

endmodule
`default_nettype wire
